>>> hw/rtl/gfau_pkg.sv
// Shared types and constants for the GF(2^8) arithmetic unit.
// Used by gfau_mul, gfau_seq and gf256_arithmetic_unit_core; no dependencies.
`default_nettype none

package gfau_pkg;

    localparam int GF_W = 8;

    // reduction byte after reset: x^8 + x^4 + x^3 + x + 1
    localparam logic [GF_W-1:0] POLY_RESET = 8'h1B;

    localparam logic [1:0] CMD_ADD = 2'd0;
    localparam logic [1:0] CMD_SUB = 2'd1;
    localparam logic [1:0] CMD_MUL = 2'd2;
    localparam logic [1:0] CMD_INV = 2'd3;

    // scratch memory rows
    localparam logic SLOT_A = 1'b0;
    localparam logic SLOT_X = 1'b1;

    // a^254 chain: a^2, a^3, a^6, a^7, ... a^126, a^127, a^254
    localparam int INV_STEPS = 13;
    localparam int STEP_W    = $clog2(INV_STEPS);
    localparam logic [STEP_W-1:0] INV_LAST = STEP_W'(INV_STEPS - 1);

    typedef struct packed {
        logic [1:0]      command;
        logic [GF_W-1:0] operand_a;
        logic [GF_W-1:0] operand_b;
    } gfau_in_t;

    typedef struct packed {
        logic [GF_W-1:0] result;
        logic            no_inverse;
    } gfau_out_t;

    typedef struct packed {
        logic            start;
        logic [GF_W-1:0] x;
        logic [GF_W-1:0] y;
    } gfau_mul_req_t;

    typedef struct packed {
        logic            done;
        logic [GF_W-1:0] product;
    } gfau_mul_rsp_t;

endpackage

`default_nettype wire

>>> hw/rtl/gfau_mul.sv
// Bit-serial GF(2^8) multiplier: one bit of the multiplier per cycle.
// Depends on gfau_pkg for widths and the request/response structs.
`default_nettype none

module gfau_mul import gfau_pkg::*; (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic [GF_W-1:0] poly,
    input  wire gfau_mul_req_t   req,
    output gfau_mul_rsp_t        rsp
);

    localparam int CNT_W = $clog2(GF_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(GF_W - 1);

    logic [GF_W-1:0]  x_reg;
    logic [GF_W-1:0]  y_reg;
    logic [GF_W-1:0]  acc_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [GF_W-1:0]  x_dbl;

    // double the multiplicand, fold the polynomial back in on overflow
    assign x_dbl = x_reg[GF_W-1] ? ({x_reg[GF_W-2:0], 1'b0} ^ poly)
                                 : {x_reg[GF_W-2:0], 1'b0};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                x_reg    <= req.x;
                y_reg    <= req.y;
                acc_reg  <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                if (y_reg[0]) begin
                    acc_reg <= acc_reg ^ x_reg;
                end
                x_reg   <= x_dbl;
                y_reg   <= y_reg >> 1;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done    = done_reg;
    assign rsp.product = acc_reg;

endmodule

`default_nettype wire

>>> hw/rtl/gfau_seq.sv
// Operation sequencer: decodes a command, runs the multiplier, and keeps the
// inversion operands in a two-row scratch memory. Depends on gfau_pkg, gfau_mul.
`default_nettype none

module gfau_seq import gfau_pkg::*; (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic [GF_W-1:0] poly,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire gfau_in_t        in_data,
    output logic                 res_valid,
    input  wire logic            res_take,
    output gfau_out_t            res_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_LD,
        ST_MUL,
        ST_DONE
    } state_t;

    state_t            state_reg, state_next;
    logic [1:0]        cmd_reg, cmd_next;
    logic [STEP_W-1:0] step_reg, step_next;
    gfau_out_t         res_reg, res_next;

    logic [GF_W-1:0] mem [0:1];
    logic [GF_W-1:0] rd0_reg, rd1_reg;
    logic            rd_addr0, rd_addr1;
    logic            mem_we;
    logic            mem_waddr;
    logic [GF_W-1:0] mem_wdata;

    gfau_mul_req_t mul_req;
    gfau_mul_rsp_t mul_rsp;

    gfau_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .poly    (poly),
        .req     (mul_req),
        .rsp     (mul_rsp)
    );

    // chain: first step squares a, odd steps multiply by a, even steps square
    assign rd_addr0 = (step_reg == '0) ? SLOT_A : SLOT_X;
    assign rd_addr1 = ((step_reg == '0) || step_reg[0]) ? SLOT_A : SLOT_X;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd0_reg <= mem[rd_addr0];
        rd1_reg <= mem[rd_addr1];
    end

    always_comb begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        step_next   = step_reg;
        res_next    = res_reg;
        mem_we      = 1'b0;
        mem_waddr   = SLOT_A;
        mem_wdata   = in_data.operand_a;
        mul_req.start = 1'b0;
        mul_req.x     = rd0_reg;
        mul_req.y     = rd1_reg;

        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd_next  = in_data.command;
                    step_next = '0;
                    case (in_data.command)
                        CMD_ADD, CMD_SUB: begin
                            res_next.result     = in_data.operand_a ^ in_data.operand_b;
                            res_next.no_inverse = 1'b0;
                            state_next          = ST_DONE;
                        end
                        CMD_MUL: begin
                            mul_req.start = 1'b1;
                            mul_req.x     = in_data.operand_a;
                            mul_req.y     = in_data.operand_b;
                            state_next    = ST_MUL;
                        end
                        default: begin
                            // inverse: zero has none, else park a in the scratch row
                            if (in_data.operand_a == '0) begin
                                res_next.result     = '0;
                                res_next.no_inverse = 1'b1;
                                state_next          = ST_DONE;
                            end else begin
                                mem_we     = 1'b1;
                                state_next = ST_RD;
                            end
                        end
                    endcase
                end
            end
            ST_RD: begin
                state_next = ST_LD;
            end
            ST_LD: begin
                mul_req.start = 1'b1;
                state_next    = ST_MUL;
            end
            ST_MUL: begin
                if (mul_rsp.done) begin
                    res_next.result     = mul_rsp.product;
                    res_next.no_inverse = 1'b0;
                    if (cmd_reg == CMD_MUL) begin
                        state_next = ST_DONE;
                    end else begin
                        mem_we    = 1'b1;
                        mem_waddr = SLOT_X;
                        mem_wdata = mul_rsp.product;
                        if (step_reg == INV_LAST) begin
                            state_next = ST_DONE;
                        end else begin
                            step_next  = step_reg + 1'b1;
                            state_next = ST_RD;
                        end
                    end
                end
            end
            ST_DONE: begin
                if (res_take) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
        cmd_reg <= cmd_next;
        res_reg <= res_next;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res_data  = res_reg;

endmodule

`default_nettype wire

>>> hw/rtl/gf256_arithmetic_unit_core.sv
// GF(2^8) arithmetic unit, top level: handshake ports, polynomial register, output stage.
// Depends on gfau_pkg and gfau_seq (which holds gfau_mul).
//
// Each input beat carries a command and two bytes and yields exactly one result
// beat. Add and subtract return a XOR b. Multiply is shift-and-add over the eight
// bits of operand_b, folding in the reduction byte (reset 0x1B, the AES field)
// whenever the running multiplicand overflows bit 7. Inverse returns a^254 under
// the configured reduction, which is the true inverse only for an irreducible
// polynomial; inverse of zero returns 0 with no_inverse set. One item is in work
// at a time, but an output register holds a finished result so the next item can
// be accepted while the consumer stalls. Multiply and inverse are paced by the
// bit-serial multiplier; an inverse runs thirteen products (a^2, a^3, a^6, a^7,
// ... a^127, a^254), each one read from a two-row scratch memory through a
// registered read port, multiplied, and written back before the next read is
// issued, so no forwarding is needed. Write cfg_wr_data into the polynomial
// register with cfg_wr_en only while the unit is idle.
`default_nettype none

module gf256_arithmetic_unit_core import gfau_pkg::*; (
    input  wire logic            aclk,
    input  wire logic            aresetn,

    input  wire logic            cfg_wr_en,
    input  wire logic [GF_W-1:0] cfg_wr_data,

    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire gfau_in_t        s_data,

    output logic                 m_valid,
    input  wire logic            m_ready,
    output gfau_out_t            m_data
);

    logic [GF_W-1:0] poly_reg;
    logic            m_valid_reg;
    gfau_out_t       m_data_reg;

    logic            res_valid;
    logic            res_take;
    gfau_out_t       res_data;

    gfau_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .poly      (poly_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res_data  (res_data)
    );

    // advance a finished result into the output stage when it is empty or draining
    assign res_take = res_valid && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            poly_reg    <= POLY_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                poly_reg <= cfg_wr_data;
            end
            if (res_take) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                // drop the beat once taken
                m_valid_reg <= 1'b0;
            end
        end
        if (res_take) begin
            m_data_reg <= res_data;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire
